// ===== hdl/label_voxel_count_ledger_assert.svh =====
// Assertion macros shared by the checker of the label voxel count ledger.
// Depends on nothing; included by the files that hold concurrent assertions.
`ifndef LABEL_VOXEL_COUNT_LEDGER_ASSERT_SVH
`define LABEL_VOXEL_COUNT_LEDGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LVCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LVCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/lvcl_pkg.sv =====
// Package of the label voxel count ledger: sizes, the queued operation type
// and the count reporting function. Depends on nothing.
package lvcl_pkg;

    localparam int LABEL_BITS   = 16;
    localparam int COUNT_BITS   = 32;
    localparam int REPORT_BITS  = 32;
    localparam int TALLY_BITS   = 16;
    localparam int IN_LABEL_W   = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int WIDE_BITS    = (COUNT_BITS > REPORT_BITS) ? COUNT_BITS : REPORT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};
    localparam logic [LABEL_BITS-1:0] LABEL_LAST = {LABEL_BITS{1'b1}};

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        logic                  clear;
        logic [LABEL_BITS-1:0] before_label;
        logic [LABEL_BITS-1:0] after_label;
        logic                  same;
        logic                  before_bg;
        logic                  after_bg;
    } lvcl_op_t;

    // A background label reports zero; a count too wide for the result field
    // saturates to all ones.
    function automatic logic [REPORT_BITS-1:0] report_count(
        input logic                  bg,
        input logic [COUNT_BITS-1:0] count
    );
        logic [WIDE_BITS-1:0]   wide;
        logic [REPORT_BITS-1:0] res;
        wide = WIDE_BITS'(count);
        if (bg)
        begin
            res = '0;
        end
        else if (wide > WIDE_BITS'({REPORT_BITS{1'b1}}))
        begin
            res = {REPORT_BITS{1'b1}};
        end
        else
        begin
            res = wide[REPORT_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/lvcl_front.sv =====
// Front end of the label voxel count ledger: accepts items and classifies them.
// Depends on lvcl_pkg.
module lvcl_front (
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               command,
    input  logic [lvcl_pkg::IN_LABEL_W-1:0]    before_label,
    input  logic [lvcl_pkg::IN_LABEL_W-1:0]    after_label,
    input  logic                               init_busy,
    input  logic                               q_full,
    output logic                               q_push,
    output lvcl_pkg::lvcl_op_t                 q_op
);

    logic [lvcl_pkg::LABEL_BITS-1:0] before_m;
    logic [lvcl_pkg::LABEL_BITS-1:0] after_m;

    // Only the low label bits index the table.
    assign before_m = before_label[lvcl_pkg::LABEL_BITS-1:0];
    assign after_m  = after_label[lvcl_pkg::LABEL_BITS-1:0];

    assign item_stall = q_full || init_busy;
    assign q_push     = item_valid && !item_stall;

    always_comb
    begin
        q_op.clear        = (command == lvcl_pkg::CMD_CLEAR);
        q_op.before_label = before_m;
        q_op.after_label  = after_m;
        q_op.same         = (before_m == after_m);
        q_op.before_bg    = (before_m == '0);
        q_op.after_bg     = (after_m == '0);
    end

endmodule

// ===== hdl/lvcl_queue.sv =====
// Short queue of classified operations between front and back.
// Depends on lvcl_pkg.
module lvcl_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lvcl_pkg::lvcl_op_t push_op,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output lvcl_pkg::lvcl_op_t pop_op
);

    lvcl_pkg::lvcl_op_t                  entry_reg [lvcl_pkg::QUEUE_DEPTH];
    logic [lvcl_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [lvcl_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [lvcl_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [lvcl_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [lvcl_pkg::QUEUE_PTR_W:0]      fill_reg;
    logic [lvcl_pkg::QUEUE_PTR_W:0]      fill_next;

    assign full      = (fill_reg == (lvcl_pkg::QUEUE_PTR_W + 1)'(lvcl_pkg::QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== hdl/lvcl_back.sv =====
// Back end of the label voxel count ledger: count memory, update sequencer,
// clearing sweep and result register. Depends on lvcl_pkg.
module lvcl_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  lvcl_pkg::lvcl_op_t                  q_op,
    output logic                                q_pop,
    output logic                                init_busy,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                inconsistent,
    output logic [lvcl_pkg::REPORT_BITS-1:0]    before_count,
    output logic [lvcl_pkg::REPORT_BITS-1:0]    after_count,
    output logic [lvcl_pkg::TALLY_BITS-1:0]     distinct_labels
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CALC   = 2'd1;
    localparam logic [1:0] S_CLR    = 2'd2;
    localparam logic [1:0] S_CLRRES = 2'd3;

    localparam int LB = lvcl_pkg::LABEL_BITS;
    localparam int CB = lvcl_pkg::COUNT_BITS;
    localparam int RB = lvcl_pkg::REPORT_BITS;
    localparam int TB = lvcl_pkg::TALLY_BITS;

    logic [CB-1:0] mem [2**LB];

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    lvcl_pkg::lvcl_op_t  op_reg;
    logic [LB-1:0]       clr_cnt_reg;
    logic [LB-1:0]       clr_cnt_next;
    logic                clr_reply_reg;
    logic                clr_reply_next;
    logic [TB-1:0]       tally_reg;
    logic [TB-1:0]       tally_next;
    logic                pw_valid_reg;
    logic                pw_valid_next;
    logic [LB-1:0]       pw_addr_reg;
    logic [CB-1:0]       pw_data_reg;
    logic                fwd_valid_reg;
    logic [LB-1:0]       fwd_addr_reg;
    logic [CB-1:0]       fwd_data_reg;
    logic [CB-1:0]       rd_b_reg;
    logic [CB-1:0]       rd_a_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_inc_reg;
    logic [RB-1:0]       out_bc_reg;
    logic [RB-1:0]       out_ac_reg;
    logic [TB-1:0]       out_dl_reg;

    logic          out_free;
    logic          commit;
    logic          clr_reply_load;
    logic [CB-1:0] cb;
    logic [CB-1:0] ca;
    logic          bad;
    logic          do_upd;
    logic          wr_before;
    logic          wr_after;
    logic [CB-1:0] nb;
    logic [CB-1:0] na;
    logic          tally_dec;
    logic          tally_inc;
    logic          we;
    logic [LB-1:0] waddr;
    logic [CB-1:0] wdata;

    assign out_free  = !out_valid_reg || !result_stall;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign init_busy = (state_reg == S_CLR) && !clr_reply_reg;
    assign commit    = (state_reg == S_CALC) && out_free;
    assign clr_reply_load = (state_reg == S_CLRRES) && out_free;

    // The after count of the previous item may be written in the same cycle
    // as this item's read, so that value is forwarded.
    always_comb
    begin
        cb = (fwd_valid_reg && fwd_addr_reg == op_reg.before_label) ? fwd_data_reg : rd_b_reg;
        ca = (fwd_valid_reg && fwd_addr_reg == op_reg.after_label) ? fwd_data_reg : rd_a_reg;
        bad       = !op_reg.same && !op_reg.before_bg && (cb == '0);
        do_upd    = !op_reg.same && !bad;
        wr_before = do_upd && !op_reg.before_bg;
        wr_after  = do_upd && !op_reg.after_bg;
        nb        = cb - 1'b1;
        na        = (ca == lvcl_pkg::COUNT_TOP) ? ca : ca + 1'b1;
        tally_dec = wr_before && (cb == CB'(1));
        tally_inc = wr_after && (ca == '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        tally_next     = tally_reg;
        pw_valid_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_op.clear)
                    begin
                        state_next     = S_CLR;
                        clr_cnt_next   = '0;
                        clr_reply_next = 1'b1;
                        tally_next     = '0;
                    end
                    else
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                if (commit)
                begin
                    state_next    = S_IDLE;
                    tally_next    = tally_reg - TB'(tally_dec) + TB'(tally_inc);
                    pw_valid_next = wr_after;
                end
            end
            S_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == lvcl_pkg::LABEL_LAST)
                begin
                    state_next = clr_reply_reg ? S_CLRRES : S_IDLE;
                end
            end
            S_CLRRES:
            begin
                if (clr_reply_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // One write port: sweep, before count at commit, then after count.
    always_comb
    begin
        we    = 1'b0;
        waddr = pw_addr_reg;
        wdata = pw_data_reg;
        if (state_reg == S_CLR)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else if (commit && wr_before)
        begin
            we    = 1'b1;
            waddr = op_reg.before_label;
            wdata = nb;
        end
        else if (pw_valid_reg)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (q_pop)
        begin
            rd_b_reg <= mem[q_op.before_label];
            rd_a_reg <= mem[q_op.after_label];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit || clr_reply_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            tally_reg     <= '0;
            pw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            tally_reg     <= tally_next;
            pw_valid_reg  <= pw_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg        <= q_op;
            fwd_valid_reg <= pw_valid_reg;
            fwd_addr_reg  <= pw_addr_reg;
            fwd_data_reg  <= pw_data_reg;
        end
        if (commit)
        begin
            pw_addr_reg <= op_reg.after_label;
            pw_data_reg <= na;
            out_inc_reg <= bad;
            out_bc_reg  <= lvcl_pkg::report_count(op_reg.before_bg, do_upd ? nb : cb);
            out_ac_reg  <= lvcl_pkg::report_count(op_reg.after_bg, do_upd ? na : ca);
            out_dl_reg  <= tally_next;
        end
        else if (clr_reply_load)
        begin
            out_inc_reg <= 1'b0;
            out_bc_reg  <= '0;
            out_ac_reg  <= '0;
            out_dl_reg  <= '0;
        end
    end

    assign result_valid    = out_valid_reg;
    assign inconsistent    = out_inc_reg;
    assign before_count    = out_bc_reg;
    assign after_count     = out_ac_reg;
    assign distinct_labels = out_dl_reg;

endmodule

// ===== hdl/label_voxel_count_ledger.sv =====
// Top level of the label voxel count ledger, a voxel-count histogram over labels.
// Depends on lvcl_pkg, lvcl_front, lvcl_queue and lvcl_back.
//
//   channel  handshake                  payload
//   item     item_valid/item_stall      command, before_label, after_label
//   result   result_valid/result_stall  inconsistent, before_count, after_count, distinct_labels
//
// An update in the back end is a registered read of the count memory, then
// compute and commit, which waits while a stalled result is still held.
// A clear sweeps the count memory one entry a cycle, then loads the reply.
// After reset the same sweep runs with item_stall high.
// The result register and a two-entry queue let either side stall on its own.
module label_voxel_count_ledger (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic [lvcl_pkg::IN_LABEL_W-1:0]     before_label,
    input  logic [lvcl_pkg::IN_LABEL_W-1:0]     after_label,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                inconsistent,
    output logic [lvcl_pkg::REPORT_BITS-1:0]    before_count,
    output logic [lvcl_pkg::REPORT_BITS-1:0]    after_count,
    output logic [lvcl_pkg::TALLY_BITS-1:0]     distinct_labels
);

    lvcl_pkg::lvcl_op_t push_op;
    lvcl_pkg::lvcl_op_t pop_op;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic               init_busy;

    // The front masks the labels and works out the special cases of each
    // transfer so that the back only reads the flags.
    lvcl_front u_front (
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .before_label (before_label),
        .after_label  (after_label),
        .init_busy    (init_busy),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (push_op)
    );

    // Decouples acceptance from the memory sequencer.
    lvcl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_op   (push_op),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_op    (pop_op)
    );

    // The back owns the count memory, the label tally and the result register.
    lvcl_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_op            (pop_op),
        .q_pop           (q_pop),
        .init_busy       (init_busy),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .inconsistent    (inconsistent),
        .before_count    (before_count),
        .after_count     (after_count),
        .distinct_labels (distinct_labels)
    );

endmodule

// ===== hdl/lvcl_checker.sv =====
// Port-level checker of the label voxel count ledger and its bind.
// Depends on lvcl_pkg and label_voxel_count_ledger_assert.svh.
`include "label_voxel_count_ledger_assert.svh"

module lvcl_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic                                inconsistent,
    input  logic [lvcl_pkg::REPORT_BITS-1:0]    before_count,
    input  logic [lvcl_pkg::REPORT_BITS-1:0]    after_count,
    input  logic [lvcl_pkg::TALLY_BITS-1:0]     distinct_labels
);

    // A stalled result stays offered.
    `LVCL_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid)

    // A stalled result keeps its payload.
    `LVCL_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && result_stall,
        $stable(inconsistent) && $stable(before_count) &&
        $stable(after_count) && $stable(distinct_labels))

    // An inconsistent update found a zero before count.
    `LVCL_ASSERT_NOW(a_incons_zero, clk, rst_n, result_valid && inconsistent, before_count == '0)

    // Any nonzero reported count means at least one label is present.
    `LVCL_ASSERT_NOW(a_tally_nonzero, clk, rst_n,
        result_valid && (before_count != '0 || after_count != '0), distinct_labels != '0)

endmodule

bind label_voxel_count_ledger lvcl_checker u_lvcl_checker (.*);
